// ===== rtl/core/rolling_window_temp_stats_core_assert.svh =====
// Assertion macros used by the checker file of the rolling window core.
// No dependencies; included by bare file name.
`ifndef ROLLING_WINDOW_TEMP_STATS_CORE_ASSERT_SVH
`define ROLLING_WINDOW_TEMP_STATS_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RWTS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RWTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rwts_pkg.sv =====
// Package for the rolling window temperature statistics core.
// Item types, field widths and reset constants; no dependencies.
`default_nettype none

package rwts_pkg;

	localparam int unsigned WINDOW_DEF = 10;
	localparam int unsigned TEMP_W     = 16;
	localparam int unsigned COMP_W     = 32;
	localparam int unsigned QUO_W      = 16;

	// 45.0 degC in 1/16 degree steps
	localparam logic signed [TEMP_W-1:0] THRESH_RST = 16'sd720;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic        [COMP_W-1:0] companion_value;
	} in_item_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] window_mean;
		logic signed [TEMP_W-1:0] window_min;
		logic signed [TEMP_W-1:0] window_max;
		logic        [COMP_W-1:0] companion_out;
		logic                     over_threshold;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/rolling_window_temp_stats_core.sv =====
// Rolling window temperature statistics core: mean, min and max over a ring.
// Depends on rwts_pkg, rwts_ring and rwts_div.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------
//   in      | in_valid/in_stall  | in_item  (rwts_pkg::in_item_t)
//   out     | out_valid/out_stall| out_item (rwts_pkg::out_item_t)
//   cfg     | cfg_we             | cfg_data (alert threshold)
//
// One item at a time, through the ring scan (one read per valid entry) and the
// 16-step divider. The result sits in an output register; the next item is
// taken while it waits.
// Reset (arst_n, async) empties the ring logically: fill count and write slot
// go to zero, threshold to 45.0 degC. Ring contents are not cleared.
// A stalled output only holds the core once the next result is ready.
`default_nettype none

module rolling_window_temp_stats_core #(
	parameter int unsigned WINDOW = rwts_pkg::WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic signed [rwts_pkg::TEMP_W-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  rwts_pkg::in_item_t                 in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output rwts_pkg::out_item_t                out_item
);
	import rwts_pkg::*;

	localparam int unsigned AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	// one spare bit so the magnitude split at QUO_W is never empty
	localparam int unsigned SUM_W = TEMP_W + 1 + $clog2(WINDOW);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_LAST = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t                    state_q;
	logic signed [TEMP_W-1:0]  thresh_q;
	logic [AW-1:0]             slot_q;
	logic [CNT_W-1:0]          fill_q;
	logic [AW-1:0]             idx_q;
	logic                      rvld_s1;
	logic                      first_s1;
	logic                      div_go_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [TEMP_W-1:0]  min_q;
	logic signed [TEMP_W-1:0]  max_q;
	logic signed [TEMP_W-1:0]  mean_q;
	logic [COMP_W-1:0]         comp_q;
	logic                      over_q;
	logic                      out_valid_q;
	out_item_t                 out_item_q;

	logic                      in_acc;
	logic                      out_free;
	logic                      ring_re;
	logic signed [TEMP_W-1:0]  ring_rdata;
	logic [SUM_W-1:0]          sum_mag;
	logic                      div_done;
	logic [QUO_W-1:0]          div_quo;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign ring_re   = (state_q == ST_SCAN);

	// new sample goes straight into the ring at acceptance; the scan starts in the
	// next cycle, so it always sees it
	rwts_ring #(
		.WINDOW (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (in_acc),
		.waddr (slot_q),
		.wdata (in_item.temperature),
		.re    (ring_re),
		.raddr (idx_q),
		.rdata (ring_rdata)
	);

	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	rwts_div #(
		.MAG_W (SUM_W),
		.DIV_W (CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_go_q),
		.mag     (sum_mag),
		.divisor (fill_q),
		.done    (div_done),
		.quo     (div_quo)
	);

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
		end else if (cfg_we) begin
			thresh_q <= cfg_data;
		end
	end

	// sequencer, ring pointers, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			rvld_s1     <= 1'b0;
			first_s1    <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvld_s1  <= ring_re;
			first_s1 <= ring_re && (idx_q == '0);
			div_go_q <= (state_q == ST_LAST);
			// a new result replaces a taken one in the same cycle
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						slot_q  <= (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
						// saturate: divisor stays in 1..WINDOW
						if (fill_q != CNT_W'(WINDOW)) begin
							fill_q <= fill_q + 1'b1;
						end
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (CNT_W'(idx_q) == fill_q - 1'b1) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// last read word is folded in at this edge
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item payload: sample side info, running sum / min / max, mean
	always_ff @(posedge clk) begin
		if (in_acc) begin
			comp_q <= in_item.companion_value;
			over_q <= (in_item.temperature > thresh_q);
		end
		if (rvld_s1) begin
			if (first_s1) begin
				sum_q <= SUM_W'(ring_rdata);
				min_q <= ring_rdata;
				max_q <= ring_rdata;
			end else begin
				sum_q <= sum_q + SUM_W'(ring_rdata);
				if (ring_rdata < min_q) begin
					min_q <= ring_rdata;
				end
				if (ring_rdata > max_q) begin
					max_q <= ring_rdata;
				end
			end
		end
		if (div_done) begin
			// truncation toward zero: divide magnitude, restore sign
			mean_q <= sum_q[SUM_W-1] ? TEMP_W'(-div_quo) : TEMP_W'(div_quo);
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_item_q.window_mean    <= mean_q;
			out_item_q.window_min     <= min_q;
			out_item_q.window_max     <= max_q;
			out_item_q.companion_out  <= comp_q;
			out_item_q.over_threshold <= over_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/core/rwts_ring.sv =====
// Sample ring: one write port, one read port, registered read data.
// Depends on rwts_pkg for the sample width.
`default_nettype none

module rwts_ring #(
	parameter  int unsigned WINDOW = rwts_pkg::WINDOW_DEF,
	localparam int unsigned AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic [rwts_pkg::TEMP_W-1:0]     wdata,
	input  logic                            re,
	input  logic [AW-1:0]                   raddr,
	output logic [rwts_pkg::TEMP_W-1:0]     rdata
);
	import rwts_pkg::*;

	logic [TEMP_W-1:0] mem [WINDOW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rwts_div.sv =====
// Serial restoring divider: one quotient bit per cycle, QUO_W bits in all.
// Depends on rwts_pkg for the quotient width.
`default_nettype none

module rwts_div #(
	parameter int unsigned MAG_W = 21,
	parameter int unsigned DIV_W = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [MAG_W-1:0]            mag,
	input  logic [DIV_W-1:0]            divisor,
	output logic                        done,
	output logic [rwts_pkg::QUO_W-1:0]  quo
);
	import rwts_pkg::*;

	localparam int unsigned CW = $clog2(QUO_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [DIV_W:0]    trial;
	logic              qbit;

	// caller guarantees the quotient fits QUO_W bits, so mag >> QUO_W < divisor
	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign qbit  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_W'(mag >> QUO_W);
			dvd_q <= mag[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q <= qbit ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
			dvd_q <= {dvd_q[QUO_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;

endmodule

`default_nettype wire

// ===== rtl/core/rwts_chk.sv =====
// Port-level checker for the rolling window core, bound to the top level.
// Depends on rwts_pkg and rolling_window_temp_stats_core_assert.svh.
`default_nettype none

`include "rolling_window_temp_stats_core_assert.svh"

module rwts_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input rwts_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_stall,
	input rwts_pkg::out_item_t out_item
);
	import rwts_pkg::*;

	logic in_acc;
	logic in_seen;

	assign in_acc  = in_valid && !in_stall;
	// payload only watched for X-free use in the accept term
	assign in_seen = in_acc && (in_item.temperature == in_item.temperature);

`RWTS_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_seen, in_stall, "item accepted while busy")
`RWTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
`RWTS_ASSERT_SAME(a_min_le_max, clk, arst_n, out_valid, out_item.window_min <= out_item.window_max, "min above max")
`RWTS_ASSERT_SAME(a_mean_in_range, clk, arst_n, out_valid, (out_item.window_mean >= out_item.window_min) && (out_item.window_mean <= out_item.window_max), "mean outside min..max")

endmodule

bind rolling_window_temp_stats_core rwts_chk u_rwts_chk (.*);

`default_nettype wire

// ===== bench/rwts_checker.sv =====
`timescale 1ns / 1ps
// Checker for the rolling window temperature statistics core: tracks the sample ring,
// forecasts each result item and compares it with what the core delivers.
// Depends on rwts_pkg for the item types and the threshold reset value.
module rwts_checker #(
	parameter int unsigned WINDOW = rwts_pkg::WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic signed [rwts_pkg::TEMP_W-1:0] cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  rwts_pkg::in_item_t                 in_item,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  rwts_pkg::out_item_t                out_item,
	output int unsigned                        mismatches,
	output int unsigned                        stats_pending
);
	import rwts_pkg::*;

	logic signed [TEMP_W-1:0] ring [WINDOW];
	int unsigned              next_slot;
	int unsigned              filled;
	logic signed [TEMP_W-1:0] threshold;
	out_item_t                stats_due [$];

	// store the sample, then mean/min/max over slots 0 .. filled-1
	function automatic out_item_t fold_sample(in_item_t it);
		out_item_t                r;
		int                       sum;
		logic signed [TEMP_W-1:0] lo;
		logic signed [TEMP_W-1:0] hi;
		logic signed [TEMP_W-1:0] s;
		ring[next_slot] = it.temperature;
		next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
		if (filled < WINDOW)
			filled++;
		sum = 0;
		lo = ring[0];
		hi = ring[0];
		for (int i = 0; i < filled; i++) begin
			s = ring[i];
			sum += s;
			if (s < lo)
				lo = s;
			if (s > hi)
				hi = s;
		end
		r.window_mean    = TEMP_W'(sum / int'(filled));
		r.window_min     = lo;
		r.window_max     = hi;
		r.companion_out  = it.companion_value;
		r.over_threshold = (it.temperature > threshold);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			threshold  = THRESH_RST;
			next_slot  = 0;
			filled     = 0;
			mismatches = 0;
			stats_due.delete();
		end else begin
			if (cfg_we)
				threshold = cfg_data;
			// results first: a result can never belong to an item taken on the same edge
			if (out_valid && !out_stall) begin
				if (stats_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t unexpected result: mean %0d min %0d max %0d comp %h alert %b",
							$time, out_item.window_mean, out_item.window_min,
							out_item.window_max, out_item.companion_out, out_item.over_threshold);
					mismatches++;
				end else begin
					want = stats_due.pop_front();
					if (out_item.window_mean !== want.window_mean
						|| out_item.window_min !== want.window_min
						|| out_item.window_max !== want.window_max
						|| out_item.companion_out !== want.companion_out
						|| out_item.over_threshold !== want.over_threshold) begin
						if (mismatches < 10)
							$display("%0t mismatch: exp mean %0d min %0d max %0d comp %h alert %b / got mean %0d min %0d max %0d comp %h alert %b",
								$time, want.window_mean, want.window_min, want.window_max,
								want.companion_out, want.over_threshold,
								out_item.window_mean, out_item.window_min,
								out_item.window_max, out_item.companion_out,
								out_item.over_threshold);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				stats_due.push_back(fold_sample(in_item));
		end
		stats_pending = stats_due.size();
	end

endmodule

// ===== bench/tb_rolling_window_temp_stats_core.sv =====
`timescale 1ns / 1ps
// Testbench top for rolling_window_temp_stats_core: clock, reset, threshold writes and
// sample stimulus. Forecasting and comparison sit in rwts_checker; uses rwts_pkg.
module tb_rolling_window_temp_stats_core;
	import rwts_pkg::*;

	// wait after the last result so that the core is surely idle, with margin
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PHASES        = 5;
	localparam int unsigned PHASE_ITEMS   = 100;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we;
	logic signed [TEMP_W-1:0] cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	in_item_t                 in_item;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	out_item_t                out_item;

	int unsigned              mismatches;
	int unsigned              stats_pending;

	// no idling on either side while calm is set
	bit                       calm      = 1'b0;
	logic signed [TEMP_W-1:0] cur_thr   = THRESH_RST;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	rolling_window_temp_stats_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	rwts_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_item       (in_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_item      (out_item),
		.mismatches    (mismatches),
		.stats_pending (stats_pending)
	);

	// receiver back-pressure: stall chance of roughly 15 in a hundred, none while calm
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 15);
	end

	// Offer one sample item and hold it until taken. A random idle gap may come
	// first. Returns at the accepting edge with in_valid still
	// high, so back-to-back items never lower and raise valid in the same step.
	task automatic send_sample(input logic signed [TEMP_W-1:0] temp,
		input logic [COMP_W-1:0] comp);
		while (!calm && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item.temperature     <= temp;
		in_item.companion_value <= comp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Let every forecast result arrive, then give the core time to go idle.
	// The first edge lets the checker book the item accepted on the last one.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (stats_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// threshold write, only ever called with the core idle
	task automatic write_threshold(input logic signed [TEMP_W-1:0] thr);
		cfg_we   <= 1'b1;
		cfg_data <= thr;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_thr  = thr;
	endtask

	// Sample mix: the two extremes, a cluster around the current threshold so the
	// strict "greater than" gets exercised, everyday temperatures, and full-range noise.
	function automatic logic signed [TEMP_W-1:0] pick_temp(logic signed [TEMP_W-1:0] thr);
		int k;
		k = $urandom_range(9);
		case (k)
			0: begin
				return 16'sh8000;
			end
			1: begin
				return 16'sh7fff;
			end
			2, 3: begin
				return TEMP_W'(int'(thr) + int'($urandom_range(6)) - 3);
			end
			4, 5: begin
				return TEMP_W'(int'($urandom_range(1600)) - 400);
			end
			default: begin
				return TEMP_W'($urandom);
			end
		endcase
	endfunction

	initial begin
		logic signed [TEMP_W-1:0] thr;
		in_valid <= 1'b0;
		in_item  <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, threshold still at its reset value of 45.0 degC.
		// Equal to the threshold gives no alert, one step above does.
		send_sample(16'sd720, 32'h0000_0000);
		send_sample(16'sd721, 32'hffff_ffff);
		// extremes of both fields, with alternating companion patterns
		send_sample(16'sh8000, 32'h5555_5555);
		send_sample(16'sh7fff, 32'haaaa_aaaa);
		send_sample(16'sd0, 32'h0000_0001);
		send_sample(-16'sd1, 32'h8000_0000);
		send_sample(16'sd1, 32'h7fff_ffff);
		send_sample(16'sd719, 32'h1234_5678);
		send_sample(-16'sd32767, 32'hdead_beef);
		// tenth sample fills the window; the ones after wrap the ring while the
		// fill count stays saturated
		send_sample(16'sd32766, 32'h0f0f_0f0f);
		send_sample(16'sh8000, 32'hf0f0_f0f0);
		send_sample(16'sh8000, 32'h0000_ffff);
		send_sample(16'sh7fff, 32'hffff_0000);
		send_sample(-16'sd5, 32'h0000_0005);
		settle();

		// highest threshold: nothing can exceed it
		write_threshold(16'sh7fff);
		send_sample(16'sh7fff, 32'h0000_0010);
		send_sample(16'sh8000, 32'h0000_0011);
		settle();

		// lowest threshold: everything but the minimum raises the alert
		write_threshold(16'sh8000);
		send_sample(16'sh8000, 32'h0000_0020);
		send_sample(-16'sd32767, 32'h0000_0021);
		settle();

		write_threshold(16'sd0);
		send_sample(16'sd0, 32'h0000_0030);
		send_sample(16'sd1, 32'h0000_0031);
		settle();

		// Random part: a new threshold per phase, extremes among them.
		// The second phase (p == 1) runs with no idling at all on either side.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: thr = TEMP_W'($urandom);
				1: thr = 16'sd720;
				2: thr = 16'sh7fff;
				3: thr = 16'sh8000;
				default: thr = TEMP_W'(int'($urandom_range(1600)) - 400);
			endcase
			write_threshold(thr);
			calm <= (p == 1);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(pick_temp(cur_thr), $urandom);
			settle();
		end
		calm <= 1'b0;

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: the slowest legal run needs well under a millisecond.
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
